// ===== src/cau_pkg.sv =====
package cau_pkg;

  localparam int QUO_W = 33;
  localparam int REM_W = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef struct packed {
    logic [31:0] res_real;
    logic [31:0] res_imag;
    logic        equal;
    logic        div_zero;
    logic        overflow;
  } result_t;

  // one divide lane: sign, early overflow, partial remainder, dividend bits, quotient
  typedef struct packed {
    logic             neg;
    logic             big;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic             is_div;
    lane_t            re;
    lane_t            im;
    logic [REM_W-1:0] den;
    result_t          res;
  } cell_t;

  // saturate a magnitude with sign to 32-bit two's complement, msb is overflow
  function automatic logic [32:0] sat_mag(input logic neg, input logic [64:0] m);
    logic [32:0] r;
    if (neg) begin
      if (m > 65'h0_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, (~m[31:0]) + 32'd1};
    end else begin
      if (m > 65'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, m[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== src/cau_div_cell.sv =====
module cau_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  cau_pkg::cell_t  din,
  output logic            out_valid,
  output cau_pkg::cell_t  dout
);

  // one restoring step: bring down a dividend bit, subtract if it fits
  function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l,
                                          input logic [cau_pkg::REM_W-1:0] den);
    cau_pkg::lane_t o;
    logic [64:0] t;
    logic [64:0] d;
    o = l;
    t = {l.rem, l.low[32]};
    d = {1'b0, den};
    if (t >= d) begin
      o.rem = 64'(t - d);
      o.quo = {l.quo[31:0], 1'b1};
    end else begin
      o.rem = t[63:0];
      o.quo = {l.quo[31:0], 1'b0};
    end
    o.low = {l.low[31:0], 1'b0};
    return o;
  endfunction

  cau_pkg::cell_t nxt;

  always_comb begin
    nxt = din;
    nxt.re = step(din.re, din.den);
    nxt.im = step(din.im, din.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ===== src/cau_prep.sv =====
module cau_prep #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2:0]         op,
  input  logic signed [31:0] a_real,
  input  logic signed [31:0] a_imag,
  input  logic signed [31:0] b_real,
  input  logic signed [31:0] b_imag,
  output logic               out_valid,
  output cau_pkg::cell_t     out
);

  localparam int SH = 32 - FRAC_BITS;

  function automatic logic [32:0] sat_sum(input logic [32:0] s);
    logic ovf;
    ovf = s[32] ^ s[31];
    if (ovf) return {1'b1, (s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    return {1'b0, s[31:0]};
  endfunction

  // stage 1: products and the simple ops
  logic               v1, mul1, div1;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, p_br2, p_bi2;
  cau_pkg::result_t   side1, side_next;
  logic [32:0]        s_r, s_i, d_r, d_i, f_r, f_i;

  always_comb begin
    s_r = {a_real[31], a_real} + {b_real[31], b_real};
    s_i = {a_imag[31], a_imag} + {b_imag[31], b_imag};
    d_r = {a_real[31], a_real} - {b_real[31], b_real};
    d_i = {a_imag[31], a_imag} - {b_imag[31], b_imag};
    f_r = '0;
    f_i = '0;
    side_next = '0;
    unique case (cau_pkg::op_t'(op))
      cau_pkg::OP_ADD: begin
        f_r = sat_sum(s_r);
        f_i = sat_sum(s_i);
      end
      cau_pkg::OP_SUB: begin
        f_r = sat_sum(d_r);
        f_i = sat_sum(d_i);
      end
      cau_pkg::OP_DIV: side_next.div_zero = (b_real == 32'sd0) && (b_imag == 32'sd0);
      cau_pkg::OP_CMP: side_next.equal = (a_real == b_real) && (a_imag == b_imag);
      default: ;
    endcase
    side_next.res_real = f_r[31:0];
    side_next.res_imag = f_i[31:0];
    side_next.overflow = f_r[32] | f_i[32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr  <= a_real * b_real;
      p_ii  <= a_imag * b_imag;
      p_ri  <= a_real * b_imag;
      p_ir  <= a_imag * b_real;
      p_br2 <= b_real * b_real;
      p_bi2 <= b_imag * b_imag;
      mul1  <= (op == cau_pkg::OP_MUL);
      div1  <= (op == cau_pkg::OP_DIV);
      side1 <= side_next;
    end
  end

  // stage 2: exact sums of products
  logic             v2, mul2, div2;
  logic [64:0]      x2, y2;
  logic [63:0]      den2;
  cau_pkg::result_t side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (mul1) begin
        x2 <= {p_rr[63], p_rr} - {p_ii[63], p_ii};
        y2 <= {p_ri[63], p_ri} + {p_ir[63], p_ir};
      end else begin
        x2 <= {p_rr[63], p_rr} + {p_ii[63], p_ii};
        y2 <= {p_ir[63], p_ir} - {p_ri[63], p_ri};
      end
      den2  <= 64'(p_br2) + 64'(p_bi2);
      mul2  <= mul1;
      div2  <= div1 && !side1.div_zero;
      side2 <= side1;
    end
  end

  // stage 3: sign and magnitude
  logic             v3, mul3, div3, negx, negy;
  logic [63:0]      magx, magy, den3;
  cau_pkg::result_t side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx  <= x2[64];
      negy  <= y2[64];
      magx  <= x2[64] ? 64'(-x2) : x2[63:0];
      magy  <= y2[64] ? 64'(-y2) : y2[63:0];
      den3  <= den2;
      mul3  <= mul2;
      div3  <= div2;
      side3 <= side2;
    end
  end

  // stage 4: product rounding, divide overflow check and first remainder
  logic [64:0]    tx, ty, qx, qy;
  logic [32:0]    fx, fy;
  logic [96:0]    den_sh, wx, wy;
  cau_pkg::cell_t nxt;

  always_comb begin
    tx = {magx, 1'b0} >> FRAC_BITS;
    ty = {magy, 1'b0} >> FRAC_BITS;
    qx = 65'(({1'b0, tx} + 66'd1) >> 1);
    qy = 65'(({1'b0, ty} + 66'd1) >> 1);
    fx = cau_pkg::sat_mag(negx, qx);
    fy = cau_pkg::sat_mag(negy, qy);
    den_sh = {33'd0, den3} << SH;
    wx = {33'd0, magx} << (FRAC_BITS + 1);
    wy = {33'd0, magy} << (FRAC_BITS + 1);
    nxt = '0;
    nxt.res = side3;
    if (mul3) begin
      nxt.res.res_real = fx[31:0];
      nxt.res.res_imag = fy[31:0];
      nxt.res.overflow = fx[32] | fy[32];
    end
    nxt.is_div = div3;
    nxt.den = den3;
    nxt.re.neg = negx;
    nxt.re.big = !({33'd0, magx} < den_sh);
    nxt.re.rem = magx >> SH;
    nxt.re.low = wx[32:0];
    nxt.im.neg = negy;
    nxt.im.big = !({33'd0, magy} < den_sh);
    nxt.im.rem = magy >> SH;
    nxt.im.low = wy[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= nxt;
    end
  end

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// complex arithmetic unit: add, subtract, multiply, divide and compare of two
// complex operands in signed fixed point with FRAC_BITS fraction bits (q16.16
// by default). one item in, one result item out, in order. the block takes an
// item every cycle unless a result waits on m_tready, and each item passes one
// input register, four stages of products, sums, sign split and rounding, a
// chain of 33 divide cells (one quotient bit each, restoring division) and the
// output register; every op runs through the same chain so results leave in
// order. products and quotients round to nearest with ties away from zero and
// saturate to the 32-bit range, setting overflow. a divide by zero gives zero
// parts and div_zero. a one-item skid buffer at the input takes one more item
// while a result waits on m_tready; s_tready comes from a register.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,  // op, a_real, a_imag, b_real, b_imag, zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata   // res_real, res_imag, equal, div_zero, overflow, zero pad
);

  localparam int IN_W   = 131;
  localparam int CELLS  = cau_pkg::QUO_W;

  // whole pipeline moves when the output register is free or being drained
  logic en;
  assign en = !m_tvalid || m_tready;

  // skid buffer
  logic            skid_full;
  logic [IN_W-1:0] skid_data;
  logic            feed_valid;
  logic [IN_W-1:0] feed_data;

  assign s_tready   = !skid_full;
  assign feed_valid = skid_full || s_tvalid;
  assign feed_data  = skid_full ? skid_data : s_tdata[IN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (en) begin
      skid_full <= 1'b0;
    end else if (s_tvalid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_data <= s_tdata[IN_W-1:0];
    end
  end

  // input register
  logic            v0;
  logic [IN_W-1:0] d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0 <= feed_data;
    end
  end

  // front stages
  logic           cv [0:CELLS];
  cau_pkg::cell_t cd [0:CELLS];

  cau_prep #(
    .FRAC_BITS(FRAC_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v0),
    .op       (d0[2:0]),
    .a_real   (d0[34:3]),
    .a_imag   (d0[66:35]),
    .b_real   (d0[98:67]),
    .b_imag   (d0[130:99]),
    .out_valid(cv[0]),
    .out      (cd[0])
  );

  // divide chain, one quotient bit per cell
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (cv[i]),
      .din      (cd[i]),
      .out_valid(cv[i+1]),
      .dout     (cd[i+1])
    );
  end

  // quotient carries one extra bit for rounding; big means it never fit
  function automatic logic [32:0] fin_lane(input cau_pkg::lane_t l);
    logic [32:0] rm;
    logic [64:0] m;
    rm = 33'(({1'b0, l.quo} + 34'd1) >> 1);
    m  = l.big ? '1 : {32'd0, rm};
    return cau_pkg::sat_mag(l.neg, m);
  endfunction

  cau_pkg::result_t res_next;
  logic [32:0]      fr, fi;

  always_comb begin
    fr = fin_lane(cd[CELLS].re);
    fi = fin_lane(cd[CELLS].im);
    res_next = cd[CELLS].res;
    if (cd[CELLS].is_div) begin
      res_next.res_real = fr[31:0];
      res_next.res_imag = fi[31:0];
      res_next.overflow = fr[32] | fi[32];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= cv[CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {5'd0, res_next.overflow, res_next.div_zero, res_next.equal,
                  res_next.res_imag, res_next.res_real};
    end
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LATENCY = 39;
  localparam int N_RANDOM = 750;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [2:0]       op;
    logic [31:0]      ar;
    logic [31:0]      ai;
    logic [31:0]      br;
    logic [31:0]      bi;
    bit               typed;   // expected result typed into the row
    cau_pkg::result_t want;
  } vector_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;

  cau_pkg::result_t expected_results[$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;
  int      n_div = 0;
  int      n_ovf = 0;

  complex_arithmetic_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  // saturate an exact value to the signed 32-bit range
  function automatic logic [31:0] clip(input logic signed [127:0] v, inout bit ovf);
    if (v > 128'sh7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sh8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // drop fraction bits with rounding to nearest, ties away from zero
  function automatic logic [31:0] round_product(input logic signed [127:0] v, inout bit ovf);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (v < 0) ? -v : v;
    q = (mag >> FRAC) + ((mag >> (FRAC - 1)) & 128'd1);
    return clip((v < 0) ? -$signed(q) : $signed(q), ovf);
  endfunction

  // num * 2^FRAC / den rounded to nearest, ties away from zero
  function automatic logic [31:0] round_quotient(input logic signed [127:0] num,
                                                 input logic [127:0] den, inout bit ovf);
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] r;
    mag = (num < 0) ? -num : num;
    q = (mag << FRAC) / den;
    r = (mag << FRAC) % den;
    if (2 * r >= den) q = q + 1;
    return clip((num < 0) ? -$signed(q) : $signed(q), ovf);
  endfunction

  function automatic cau_pkg::result_t complex_result(input vector_t v);
    cau_pkg::result_t res;
    bit ovf;
    logic signed [127:0] ar, ai, br, bi, den;
    res = '0;
    ovf = 1'b0;
    ar = $signed(v.ar);
    ai = $signed(v.ai);
    br = $signed(v.br);
    bi = $signed(v.bi);
    case (v.op)
      cau_pkg::OP_ADD: begin
        res.res_real = clip(ar + br, ovf);
        res.res_imag = clip(ai + bi, ovf);
      end
      cau_pkg::OP_SUB: begin
        res.res_real = clip(ar - br, ovf);
        res.res_imag = clip(ai - bi, ovf);
      end
      cau_pkg::OP_MUL: begin
        res.res_real = round_product(ar * br - ai * bi, ovf);
        res.res_imag = round_product(ar * bi + ai * br, ovf);
      end
      cau_pkg::OP_DIV: begin
        if (br == 0 && bi == 0) begin
          res.div_zero = 1'b1;
        end else begin
          den = br * br + bi * bi;
          res.res_real = round_quotient(ar * br + ai * bi, den, ovf);
          res.res_imag = round_quotient(ai * br - ar * bi, den, ovf);
        end
      end
      cau_pkg::OP_CMP: res.equal = (v.ar == v.br) && (v.ai == v.bi);
      default: ;  // unknown opcode gives an all-zero result
    endcase
    res.overflow = ovf;
    return res;
  endfunction

  task automatic report(input string what, input cau_pkg::result_t got,
                        input cau_pkg::result_t want);
    $display("error: %s got %h/%h e%0b z%0b o%0b, want %h/%h e%0b z%0b o%0b", what,
             got.res_real, got.res_imag, got.equal, got.div_zero, got.overflow,
             want.res_real, want.res_imag, want.equal, want.div_zero, want.overflow);
    fail_count++;
  endtask

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] random_part();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 8) << 16;          // small whole numbers
      4: return -($urandom_range(0, 8) << 16);
      5: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  // push one item through the input handshake and record its expected result
  task automatic send_item(input vector_t v);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, v.bi, v.br, v.ai, v.ar, v.op};
    expected_results.push_back(v.typed ? v.want : complex_result(v));
    if (v.typed && v.want != complex_result(v)) begin
      $display("error: directed row %0d disagrees with predictor", items_sent);
      fail_count++;
    end
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (v.op == cau_pkg::OP_DIV) n_div++;
    items_sent++;
  endtask

  // result side: random stalls, compare against oldest expectation
  initial begin
    cau_pkg::result_t got;
    int stall;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[63:32], m_tdata[64], m_tdata[65], m_tdata[66]};
        results_seen++;
        if (got.overflow) n_ovf++;
        if (expected_results.size() == 0) begin
          report("unexpected result", got, '0);
        end else if (got != expected_results[0]) begin
          report("field mismatch", got, expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (!rst) begin
        stall = gap_length();
        m_tready <= (stall == 0) || ($urandom_range(0, 3) == 0);
      end
    end
  end

  // watchdog over cycles without any accepted item
  initial begin
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("complex_arithmetic_unit: mismatch");
        $finish;
      end
    end
  end

  // directed rows: extremes, every op, divide by zero, compare, unknown ops
  vector_t directed[] = '{
    '{cau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b1}},
    '{cau_pkg::OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 1,
      '{32'h0004_0000, 32'h0006_0000, 1'b0, 1'b0, 1'b0}},
    '{cau_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1,
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1}},
    '{cau_pkg::OP_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 1,
      '{32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 1'b1}},
    '{cau_pkg::OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 1,
      '{32'hFFF9_0000, 32'h0016_0000, 1'b0, 1'b0, 1'b0}},
    '{cau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0},
    '{cau_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '0},
    '{cau_pkg::OP_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0, 0, '0},   // tie rounds up
    '{cau_pkg::OP_MUL, 32'hFFFF_8000, 32'h0, 32'h0000_0001, 32'h0, 0, '0},   // negative tie
    '{cau_pkg::OP_DIV, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0, 1,
      '{32'h0, 32'h0, 1'b0, 1'b1, 1'b0}},
    '{cau_pkg::OP_DIV, 32'h0006_0000, 32'h0004_0000, 32'h0002_0000, 32'h0, 1,
      '{32'h0003_0000, 32'h0002_0000, 1'b0, 1'b0, 1'b0}},
    '{cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0, 0, '0},
    '{cau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0},
    '{cau_pkg::OP_DIV, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '0},
    '{cau_pkg::OP_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0, 0, '0},
    '{cau_pkg::OP_CMP, 32'hDEAD_BEEF, 32'h8000_0000, 32'hDEAD_BEEF, 32'h8000_0000, 1,
      '{32'h0, 32'h0, 1'b1, 1'b0, 1'b0}},
    '{cau_pkg::OP_CMP, 32'hDEAD_BEEF, 32'h8000_0000, 32'hDEAD_BEEF, 32'h8000_0001, 1,
      '{32'h0, 32'h0, 1'b0, 1'b0, 1'b0}},
    '{cau_pkg::OP_CMP, 32'h0, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 1'b1, 1'b0, 1'b0}},
    '{3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '0},
    '{3'd6, 32'h1, 32'h1, 32'h1, 32'h1, 1, '0},
    '{3'd7, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1, '0}
  };

  initial begin
    vector_t v;
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (k = 0; k < directed.size(); k++) send_item(directed[k]);
    for (k = 0; k < N_RANDOM; k++) begin
      v.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      v.ar = random_part();
      v.ai = random_part();
      v.br = random_part();
      v.bi = random_part();
      if (v.op == cau_pkg::OP_CMP && $urandom_range(0, 1)) begin
        v.br = v.ar;
        v.bi = $urandom_range(0, 1) ? v.ai : v.ai ^ (32'h1 << $urandom_range(0, 31));
      end
      v.typed = 1'b0;
      v.want = '0;
      send_item(v);
    end
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    $display("sent %0d items (%0d divides), checked %0d results, %0d saturated",
             items_sent, n_div, results_seen, n_ovf);
    if (fail_count == 0) begin
      $display("complex_arithmetic_unit: match");
    end else begin
      $display("complex_arithmetic_unit: mismatch");
    end
    $finish;
  end

endmodule
